@@ sv/bdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// bdcd_pkg
// Shared types and constants of the button debounce and click detector.
// ----------------------------------------------------------------------------
package bdcd_pkg;

   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned DelayWidth   = 16;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [DelayWidth-1:0] DebounceDelayReset = 16'd50;
   localparam logic [DelayWidth-1:0] NoiseFilterReset   = 16'd20;

   localparam logic [CountWidth-1:0] ClickMax    = 4'd15;
   localparam logic [CountWidth-1:0] ClickReport = 4'd9;

   typedef enum logic [2:0] {
      REG_DEBOUNCE_DELAY = 3'd0,
      REG_NOISE_FILTER   = 3'd1,
      REG_HOLD_TIME      = 3'd2,
      REG_MULTICLICK     = 3'd3,
      REG_BISTABLE       = 3'd4,
      REG_ACTIVE_LOW     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [DelayWidth-1:0] debounce_delay_ms;
      logic [DelayWidth-1:0] noise_filter_ms;
      logic [DelayWidth-1:0] hold_time_ms;
      logic [DelayWidth-1:0] multiclick_time_ms;
      logic                  bistable_mode;
      logic                  active_low;
   } cfg_type;

   typedef struct packed {
      logic [CountWidth-1:0] click_count;
      logic                  hold_event;
      logic                  release_edge;
      logic                  press_edge;
      logic                  is_pressed;
   } result_type;

endpackage

@@ sv/button_debounce_click_detector.sv @@
// Path: an accepted sample is held in the input register, then its result is
// registered in the output register. Throughput: one sample per clock cycle
// while rsp_tready holds; the result register is free whenever it is taken.
// Reset: synchronous, active high; clears the debounce state, the valid
// flags and loads the register defaults (debounce 50, filter 20, rest 0).
// ----------------------------------------------------------------------------
// button_debounce_click_detector
// Stream wrapper with register port around the debounce and click step unit.
// ----------------------------------------------------------------------------
module button_debounce_click_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bdcd_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [bdcd_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [bdcd_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: now_ms[31:0], pin_level, zero padding.
   input  logic [bdcd_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: is_pressed, press_edge, release_edge, hold_event,
   // click_count[3:0].
   output logic [bdcd_pkg::RspDataWidth-1:0]    rsp_tdata
);

   bdcd_pkg::cfg_type                 cfg_ff;
   logic                              in_valid_ff;
   logic [bdcd_pkg::TimeWidth-1:0]    now_ff;
   logic                              pin_ff;
   logic                              out_valid_ff;
   bdcd_pkg::result_type              out_ff;
   bdcd_pkg::result_type              result;
   logic                              out_free;
   logic                              step_en;
   logic                              csr_write;
   logic [2:0]                        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_delay_ms  <= bdcd_pkg::DebounceDelayReset;
         cfg_ff.noise_filter_ms    <= bdcd_pkg::NoiseFilterReset;
         cfg_ff.hold_time_ms       <= '0;
         cfg_ff.multiclick_time_ms <= '0;
         cfg_ff.bistable_mode      <= 1'b0;
         cfg_ff.active_low         <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            bdcd_pkg::REG_DEBOUNCE_DELAY: begin
               cfg_ff.debounce_delay_ms <= csr_pwdata[15:0];
            end
            bdcd_pkg::REG_NOISE_FILTER: begin
               cfg_ff.noise_filter_ms <= csr_pwdata[15:0];
            end
            bdcd_pkg::REG_HOLD_TIME: begin
               cfg_ff.hold_time_ms <= csr_pwdata[15:0];
            end
            bdcd_pkg::REG_MULTICLICK: begin
               cfg_ff.multiclick_time_ms <= csr_pwdata[15:0];
            end
            bdcd_pkg::REG_BISTABLE: begin
               cfg_ff.bistable_mode <= csr_pwdata[0];
            end
            bdcd_pkg::REG_ACTIVE_LOW: begin
               cfg_ff.active_low <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         bdcd_pkg::REG_DEBOUNCE_DELAY: csr_prdata = {16'd0, cfg_ff.debounce_delay_ms};
         bdcd_pkg::REG_NOISE_FILTER:   csr_prdata = {16'd0, cfg_ff.noise_filter_ms};
         bdcd_pkg::REG_HOLD_TIME:      csr_prdata = {16'd0, cfg_ff.hold_time_ms};
         bdcd_pkg::REG_MULTICLICK:     csr_prdata = {16'd0, cfg_ff.multiclick_time_ms};
         bdcd_pkg::REG_BISTABLE:       csr_prdata = {31'd0, cfg_ff.bistable_mode};
         bdcd_pkg::REG_ACTIVE_LOW:     csr_prdata = {31'd0, cfg_ff.active_low};
         default:                      csr_prdata = '0;
      endcase
   end

   assign out_free   = ~out_valid_ff | rsp_tready;
   assign step_en    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         now_ff <= req_tdata[31:0];
         pin_ff <= req_tdata[32];
      end
   end

   bdcd_step u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .cfg       (cfg_ff),
      .now_ms    (now_ff),
      .pin_level (pin_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("press and release edge in the same beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_tdata[0] && rsp_tdata[7:4] == 4'd0))
      else $error("hold event while released or with a click count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:4] <= bdcd_pkg::ClickReport))
      else $error("click count above nine");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("press edge without pressed level");
`endif

endmodule

@@ sv/bdcd_step.sv @@
// ----------------------------------------------------------------------------
// bdcd_step
// Debounce state and the per-sample update: filter, edges, hold and clicks.
// ----------------------------------------------------------------------------
module bdcd_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  bdcd_pkg::cfg_type                   cfg,
   input  logic [bdcd_pkg::TimeWidth-1:0]      now_ms,
   input  logic                                pin_level,
   output bdcd_pkg::result_type                result
);

   logic [bdcd_pkg::TimeWidth-1:0]  lockout_stamp_ff, lockout_stamp_in;
   logic [bdcd_pkg::TimeWidth-1:0]  filter_stamp_ff, filter_stamp_in;
   logic [bdcd_pkg::TimeWidth-1:0]  last_change_ff, last_change_in;
   logic                            candidate_ff, candidate_in;
   logic                            stable_ff, stable_in;
   logic [bdcd_pkg::CountWidth-1:0] clicks_ff, clicks_in;
   logic                            hold_done_ff, hold_done_in;

   logic [bdcd_pkg::TimeWidth-1:0]  elapsed;
   logic [bdcd_pkg::TimeWidth-1:0]  since_lockout;
   logic [bdcd_pkg::TimeWidth-1:0]  since_filter;
   logic                            pressed_level;
   logic                            changed;
   logic                            toward_press;
   logic                            pressed_now;

   assign elapsed       = now_ms - last_change_ff;
   assign since_lockout = now_ms - lockout_stamp_ff;
   assign since_filter  = now_ms - filter_stamp_ff;
   assign pressed_level = ~cfg.active_low;

   always_comb begin
      lockout_stamp_in = lockout_stamp_ff;
      filter_stamp_in  = filter_stamp_ff;
      candidate_in     = candidate_ff;
      stable_in        = stable_ff;
      changed          = 1'b0;
      if (since_lockout > {16'd0, cfg.debounce_delay_ms}) begin
         if (pin_level != stable_ff) begin
            if (pin_level != candidate_ff) begin
               candidate_in    = pin_level;
               filter_stamp_in = now_ms;
            end else if (since_filter > {16'd0, cfg.noise_filter_ms}) begin
               lockout_stamp_in = now_ms;
               stable_in        = pin_level;
               changed          = 1'b1;
            end
         end else begin
            candidate_in = stable_ff;
         end
      end
      toward_press = (pin_level == pressed_level);
      pressed_now  = (stable_in == pressed_level);
   end

   always_comb begin
      last_change_in = last_change_ff;
      clicks_in      = clicks_ff;
      hold_done_in   = hold_done_ff;
      result         = '0;
      result.is_pressed   = pressed_now;
      result.press_edge   = changed & toward_press;
      result.release_edge = changed & ~toward_press;
      if (changed) begin
         last_change_in = now_ms;
         if ((toward_press || cfg.bistable_mode) && clicks_ff != bdcd_pkg::ClickMax) begin
            clicks_in = clicks_ff + 4'd1;
         end
      end else if (!cfg.bistable_mode && pressed_now) begin
         if (clicks_ff <= 4'd1 && cfg.hold_time_ms != '0 &&
             elapsed > {16'd0, cfg.hold_time_ms} && !hold_done_ff) begin
            result.hold_event = 1'b1;
            hold_done_in      = 1'b1;
         end
      end else if (clicks_ff != '0) begin
         if (cfg.multiclick_time_ms != '0 && elapsed > {16'd0, cfg.multiclick_time_ms}) begin
            if (!hold_done_ff && clicks_ff <= bdcd_pkg::ClickReport) begin
               result.click_count = clicks_ff;
            end
            hold_done_in = 1'b0;
            clicks_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_stamp_ff <= '0;
         filter_stamp_ff  <= '0;
         last_change_ff   <= '0;
         candidate_ff     <= 1'b0;
         stable_ff        <= 1'b0;
         clicks_ff        <= '0;
         hold_done_ff     <= 1'b0;
      end else if (step_en) begin
         lockout_stamp_ff <= lockout_stamp_in;
         filter_stamp_ff  <= filter_stamp_in;
         last_change_ff   <= last_change_in;
         candidate_ff     <= candidate_in;
         stable_ff        <= stable_in;
         clicks_ff        <= clicks_in;
         hold_done_ff     <= hold_done_in;
      end
   end

endmodule
